// ===== rtl/core/ps2mpt_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; used by ps2mpt_decode and ps2_mouse_packet_tracker_core.
package ps2mpt_pkg;

    // Default coordinate register width, handed down as a module parameter.
    localparam int COORD_BITS_DEF = 10;

    // Widths fixed by the transaction fields.
    localparam int POS_W  = 10;
    localparam int BYTE_W = 8;

    // Reset values of the limit and cursor registers.
    localparam int MAX_X_RESET    = 798;
    localparam int MAX_Y_RESET    = 598;
    localparam int CURSOR_X_RESET = 160;
    localparam int CURSOR_Y_RESET = 100;

    // Header byte bit positions.
    localparam int HDR_LEFT_BIT  = 0;
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    // Register interface.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic              from_aux;
        logic [BYTE_W-1:0] data_byte;
    } byte_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             left_button;
    } pkt_item_t;

endpackage

// ===== rtl/core/ps2mpt_decode.sv =====
// Packet assembly and cursor update for the PS/2 mouse packet tracker.
// Depends on ps2mpt_pkg for the transaction types and header bit positions.
module ps2mpt_decode #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  ps2mpt_pkg::byte_item_t item,
    input  logic [COORD_BITS-1:0]  max_x,
    input  logic [COORD_BITS-1:0]  max_y,
    output logic                   result_valid,
    output ps2mpt_pkg::pkt_item_t  result
);

    localparam int SUM_W = COORD_BITS + 2;
    localparam int POS_W = ps2mpt_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_HEADER = 3'b001,
        ST_XDELTA = 3'b010,
        ST_YDELTA = 3'b100
    } rx_state_t;

    rx_state_t                      state_reg, state_next;
    logic [ps2mpt_pkg::BYTE_W-1:0]  header_reg, header_next;
    logic [ps2mpt_pkg::BYTE_W-1:0]  xdelta_reg, xdelta_next;
    logic [COORD_BITS-1:0]          cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0]          cursor_y_reg, cursor_y_next;

    logic                           aux_fire;
    logic signed [8:0]              dx, dy;
    logic signed [SUM_W-1:0]        dx_ext, dy_ext;
    logic signed [SUM_W-1:0]        sum_x, sum_y;
    logic [COORD_BITS-1:0]          clamp_x, clamp_y;
    logic [COORD_BITS+POS_W-1:0]    wide_x, wide_y;

    assign aux_fire = fire && item.from_aux;

    // Nine-bit deltas: the data byte is the unsigned low part, the header holds the sign.
    assign dx     = {header_reg[ps2mpt_pkg::HDR_XSIGN_BIT], xdelta_reg};
    assign dy     = {header_reg[ps2mpt_pkg::HDR_YSIGN_BIT], item.data_byte};
    assign dx_ext = {{(SUM_W-9){dx[8]}}, dx};
    assign dy_ext = {{(SUM_W-9){dy[8]}}, dy};
    assign sum_x  = $signed({2'b00, cursor_x_reg}) + dx_ext;
    assign sum_y  = $signed({2'b00, cursor_y_reg}) - dy_ext;

    always_comb
    begin
        if (sum_x[SUM_W-1])
            clamp_x = '0;
        else if (sum_x[SUM_W-2:0] > {1'b0, max_x})
            clamp_x = max_x;
        else
            clamp_x = sum_x[COORD_BITS-1:0];

        if (sum_y[SUM_W-1])
            clamp_y = '0;
        else if (sum_y[SUM_W-2:0] > {1'b0, max_y})
            clamp_y = max_y;
        else
            clamp_y = sum_y[COORD_BITS-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        header_next   = header_reg;
        xdelta_next   = xdelta_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        result_valid  = 1'b0;
        if (aux_fire)
        begin
            unique case (state_reg)
                ST_HEADER:
                begin
                    // A byte without the always-one bit cannot start a packet.
                    if (item.data_byte[ps2mpt_pkg::HDR_SYNC_BIT])
                    begin
                        header_next = item.data_byte;
                        state_next  = ST_XDELTA;
                    end
                end
                ST_XDELTA:
                begin
                    xdelta_next = item.data_byte;
                    state_next  = ST_YDELTA;
                end
                ST_YDELTA:
                begin
                    cursor_x_next = clamp_x;
                    cursor_y_next = clamp_y;
                    result_valid  = 1'b1;
                    state_next    = ST_HEADER;
                end
                default:
                begin
                    state_next = ST_HEADER;
                end
            endcase
        end
    end

    assign wide_x             = {{POS_W{1'b0}}, clamp_x};
    assign wide_y             = {{POS_W{1'b0}}, clamp_y};
    assign result.pos_x       = wide_x[POS_W-1:0];
    assign result.pos_y       = wide_y[POS_W-1:0];
    assign result.left_button = header_reg[ps2mpt_pkg::HDR_LEFT_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HEADER;
            header_reg   <= '0;
            xdelta_reg   <= '0;
            cursor_x_reg <= COORD_BITS'(ps2mpt_pkg::CURSOR_X_RESET);
            cursor_y_reg <= COORD_BITS'(ps2mpt_pkg::CURSOR_Y_RESET);
        end
        else
        begin
            state_reg    <= state_next;
            header_reg   <= header_next;
            xdelta_reg   <= xdelta_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    // A completed packet always lands inside the current limits.
    a_clamp_x: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (clamp_x <= max_x) && (clamp_y <= max_y))
        else $error("cursor outside limits");

    // Bytes from the keyboard port leave the tracker untouched.
    a_non_aux: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.from_aux) |=> $stable(state_reg) && $stable(cursor_x_reg)
                                     && $stable(cursor_y_reg))
        else $error("non-mouse byte changed tracker state");

    // A misaligned header byte keeps the assembler waiting for a header.
    a_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (aux_fire && state_reg == ST_HEADER
         && !item.data_byte[ps2mpt_pkg::HDR_SYNC_BIT]) |=> state_reg == ST_HEADER)
        else $error("misaligned header was accepted");

endmodule

// ===== rtl/core/ps2_mouse_packet_tracker_core.sv =====
// Top level of the PS/2 mouse packet tracker: byte channel, packet channel,
// limit registers and output buffering. Depends on ps2mpt_pkg and ps2mpt_decode.
//
//  Channel   Handshake                       Payload             Direction
//  byte      byte_valid / byte_stall         byte_data (9 b)     in
//  pkt       pkt_valid / pkt_stall           pkt_data (21 b)     out
//  config    psel/penable/pwrite/pready      paddr, pwdata/rdata in/out
//
// One byte transaction is accepted per cycle unless byte_stall is high; the
// decoder does the header check, delta extension, add and clamp
// combinationally, feeding the output register and its skid entry.
// Reset puts the limits at 798 by 598 and the cursor at 160, 100.
// The output register plus one skid entry let byte_stall come straight from a
// flop; byte_stall rises only once two packets wait on a stalled pkt channel.
module ps2_mouse_packet_tracker_core #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Byte channel from the PS/2 controller.
    input  logic                                 byte_valid,
    output logic                                 byte_stall,
    input  ps2mpt_pkg::byte_item_t               byte_data,
    // Packet channel carrying the updated position.
    output logic                                 pkt_valid,
    input  logic                                 pkt_stall,
    output ps2mpt_pkg::pkt_item_t                pkt_data,
    // Register port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ps2mpt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ps2mpt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ps2mpt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready
);

    localparam int  DATA_W    = ps2mpt_pkg::APB_DATA_W;
    // Register index, taken from the word address bit.
    localparam logic REG_MAX_X = 1'b0;
    localparam logic REG_MAX_Y = 1'b1;

    logic [COORD_BITS-1:0]  max_x_reg, max_y_reg;
    logic                   cfg_write;

    logic                   byte_fire;
    logic                   result_valid;
    ps2mpt_pkg::pkt_item_t  result;

    logic                   out_valid_reg;
    ps2mpt_pkg::pkt_item_t  out_data_reg;
    logic                   skid_valid_reg;
    ps2mpt_pkg::pkt_item_t  skid_data_reg;
    logic                   push, pop;

    // ------------------------------------------------------------------
    // Register port: zero-wait writes in the access phase.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= COORD_BITS'(ps2mpt_pkg::MAX_X_RESET);
            max_y_reg <= COORD_BITS'(ps2mpt_pkg::MAX_Y_RESET);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MAX_X: max_x_reg <= pwdata[COORD_BITS-1:0];
                REG_MAX_Y: max_y_reg <= pwdata[COORD_BITS-1:0];
                default:   max_x_reg <= max_x_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_X: prdata = {{(DATA_W-COORD_BITS){1'b0}}, max_x_reg};
            REG_MAX_Y: prdata = {{(DATA_W-COORD_BITS){1'b0}}, max_y_reg};
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Packet assembly and position update.
    // ------------------------------------------------------------------
    assign byte_stall = skid_valid_reg;
    assign byte_fire  = byte_valid && !byte_stall;

    ps2mpt_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (byte_fire),
        .item         (byte_data),
        .max_x        (max_x_reg),
        .max_y        (max_y_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Output register with one skid entry. A new position goes to the
    // output register when it is empty or being drained this cycle, and
    // to the skid entry otherwise. The skid entry refills the output
    // register as soon as the consumer takes the current transaction.
    // ------------------------------------------------------------------
    assign push = byte_fire && result_valid;
    assign pop  = out_valid_reg && !pkt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

    assign pkt_valid = out_valid_reg;
    assign pkt_data  = out_data_reg;

    // The skid entry is only ever filled behind an occupied output register.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    // The skid entry fills only when the output register was stalled.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && pkt_stall && push))
        else $error("skid entry filled without a stalled output");

    // Draining the last waiting position with nothing new empties the buffer.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push) |=> !out_valid_reg)
        else $error("output register stayed valid after drain");

endmodule
